/* rtl/uplink_frame_counter_tracker_core_macros.svh */
// Assertion macros shared by the frame counter tracker checkers.
// Depends on nothing; included by the checker file only.
`ifndef UPLINK_FRAME_COUNTER_TRACKER_CORE_MACROS_SVH
`define UPLINK_FRAME_COUNTER_TRACKER_CORE_MACROS_SVH

// Property that must hold in the same cycle whenever out of reset.
`define UFCT_ASSERT_NOW(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked from one cycle into the next.
`define UFCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ufct_pkg.sv */
// Package for the uplink frame counter tracker: sizes, codes and item types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ufct_pkg;

   // Table size and the index width that follows from it.
   localparam int MAX_SENSORS = 8;
   localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;

   // Item commands.
   localparam logic [1:0] CMD_DATA   = 2'd0;
   localparam logic [1:0] CMD_ENROLL = 2'd1;
   localparam logic [1:0] CMD_MARK   = 2'd2;
   localparam logic [1:0] CMD_DELETE = 2'd3;

   // Result status codes.
   localparam logic [3:0] ST_UNKNOWN  = 4'd0;
   localparam logic [3:0] ST_REPLAY   = 4'd1;
   localparam logic [3:0] ST_RESEND   = 4'd2;
   localparam logic [3:0] ST_BADPAY   = 4'd3;
   localparam logic [3:0] ST_VALID    = 4'd4;
   localparam logic [3:0] ST_RESTART  = 4'd5;
   localparam logic [3:0] ST_ENROLLED = 4'd6;
   localparam logic [3:0] ST_MARKED   = 4'd7;
   localparam logic [3:0] ST_DELETED  = 4'd8;

   // Configuration register indexes (word address bit 2).
   localparam logic REG_GAP_THRESHOLD = 1'b0;
   localparam logic REG_ACK_ENABLE    = 1'b1;

   // Register reset values.
   localparam logic [31:0] GAP_THRESHOLD_RESET = 32'd50;
   localparam logic        ACK_ENABLE_RESET    = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  dev_addr;
      logic [31:0] frame_counter;
      logic        payload_ok;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic        send_downlink;
      logic        downlink_is_reset;
      logic [31:0] downlink_count;
      logic [15:0] reset_attempt_count;
      logic [31:0] lost_added;
      logic [31:0] device_lost;
      logic [31:0] all_lost;
   } rsp_type;

   // One table entry apart from its valid flag.
   typedef struct packed {
      logic        pend;
      logic        seen;
      logic [31:0] last;
      logic [31:0] lost;
      logic [31:0] down;
      logic [15:0] tries;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_in;
      logic load_rd;
      logic exec;
   } ctl_type;

endpackage

`default_nettype wire

/* rtl/uplink_frame_counter_tracker_core.sv */
// Uplink frame counter tracker: anti-replay check and loss tally for a sensor table.
// An accepted item is held in the input register, then passes the table read step and
// the table update step; the result register and its strobe are loaded at the end of
// the update step. A new item is taken during the update step of the previous one but
// not during its read step.
// Reset (synchronous, active high) empties the table, zeroes the global loss tally
// and restores the configuration registers. The receiver cannot stall results.
`default_nettype none

module uplink_frame_counter_tracker_core
   import ufct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_item,
   output logic             rsp_valid,
   output rsp_type          rsp_item,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   ctl_type     ctl;
   logic [31:0] gap_threshold;
   logic        ack_enable;

   // Configuration registers.
   ufct_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .gap_threshold (gap_threshold),
      .ack_enable    (ack_enable)
   );

   // Sequencing of each item.
   ufct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   // Table and per-item computation.
   ufct_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .req_item      (req_item),
      .gap_threshold (gap_threshold),
      .ack_enable    (ack_enable),
      .rsp_item      (rsp_item)
   );

endmodule

`default_nettype wire

/* rtl/ufct_csr.sv */
// Configuration registers of the tracker on an APB-style port.
// Depends on ufct_pkg for register indexes and reset values.
`default_nettype none

module ufct_csr
   import ufct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic [31:0]      gap_threshold,
   output logic             ack_enable
);

   logic [31:0] thr_ff, thr_in;
   logic        ack_ff, ack_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   // Register writes decode on the word address bit.
   always_comb begin
      thr_in = thr_ff;
      ack_in = ack_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_GAP_THRESHOLD: thr_in = pwdata;
            REG_ACK_ENABLE:    ack_in = pwdata[0];
            default:           thr_in = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= GAP_THRESHOLD_RESET;
         ack_ff <= ACK_ENABLE_RESET;
      end else begin
         thr_ff <= thr_in;
         ack_ff <= ack_in;
      end
   end

   // Read data.
   always_comb begin
      unique case (paddr[2])
         REG_GAP_THRESHOLD: prdata = thr_ff;
         REG_ACK_ENABLE:    prdata = {31'd0, ack_ff};
         default:           prdata = 32'd0;
      endcase
   end

   assign gap_threshold = thr_ff;
   assign ack_enable    = ack_ff;

endmodule

`default_nettype wire

/* rtl/ufct_ctrl.sv */
// Controller of the tracker: accept, table read and table update steps.
// Depends on ufct_pkg for the command struct.
`default_nettype none

module ufct_ctrl
   import ufct_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   output logic      rsp_valid,
   output ctl_type   ctl
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_WRITE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // A new item may enter while the previous one is being written back.
   assign busy   = (state_ff == S_READ);
   assign accept = start & ~busy;

   always_comb begin
      unique case (state_ff)
         S_IDLE:  state_in = accept ? S_READ : S_IDLE;
         S_READ:  state_in = S_WRITE;
         S_WRITE: state_in = accept ? S_READ : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign ctl.load_in = accept;
   assign ctl.load_rd = (state_ff == S_READ);
   assign ctl.exec    = (state_ff == S_WRITE);

   // The result register fills at the end of the update step.
   assign rsp_valid_in = ctl.exec;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/ufct_dp.sv */
// Datapath of the tracker: sensor table, read stage, update logic, result register.
// Depends on ufct_pkg for types, codes and the table size.
`default_nettype none

module ufct_dp
   import ufct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctl_type     ctl,
   input  wire req_type     req_item,
   input  wire logic [31:0] gap_threshold,
   input  wire logic        ack_enable,
   output rsp_type          rsp_item
);

   localparam logic [7:0] ADDR_MAX = 8'(MAX_SENSORS);

   // Input item register.
   req_type in_ff;

   // Sensor table: valid flags are reset, entry contents are written on enroll.
   logic [MAX_SENSORS-1:0] ev_ff, ev_in;
   entry_type              tbl_ff [MAX_SENSORS];
   logic [31:0]            total_ff, total_in;

   // Read stage registers.
   logic             s_have_ff;
   logic [IDX_W-1:0] s_idx_ff;
   logic [1:0]       s_cmd_ff;
   logic [31:0]      s_fc_ff;
   logic             s_ok_ff;
   logic             s_valid_ff;
   entry_type        s_ent_ff;
   logic             s_replay_ff;
   logic [31:0]      s_gap_ff;

   // Read stage logic.
   logic             rd_have;
   logic [7:0]       rd_addr_m1;
   logic [IDX_W-1:0] rd_idx;
   entry_type        rd_ent;

   // Update logic.
   entry_type   wr_ent;
   logic        wr_en;
   rsp_type     rsp_in;
   rsp_type     rsp_ff;

   always_ff @(posedge clock) begin
      if (ctl.load_in) begin
         in_ff <= req_item;
      end
   end

   // Address check and entry lookup.
   assign rd_have    = (in_ff.dev_addr != 8'd0) && (in_ff.dev_addr <= ADDR_MAX);
   assign rd_addr_m1 = in_ff.dev_addr - 8'd1;
   assign rd_idx     = rd_addr_m1[IDX_W-1:0];
   assign rd_ent     = tbl_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (ctl.load_rd) begin
         s_have_ff   <= rd_have;
         s_idx_ff    <= rd_idx;
         s_cmd_ff    <= in_ff.cmd;
         s_fc_ff     <= in_ff.frame_counter;
         s_ok_ff     <= in_ff.payload_ok;
         s_valid_ff  <= ev_ff[rd_idx];
         s_ent_ff    <= rd_ent;
         s_replay_ff <= rd_ent.seen && (in_ff.frame_counter <= rd_ent.last);
         s_gap_ff    <= in_ff.frame_counter - rd_ent.last - 32'd1;
      end
   end

   // Update step: classify the item and form the new entry and the result.
   always_comb begin
      wr_ent   = s_ent_ff;
      wr_en    = 1'b0;
      ev_in    = ev_ff;
      total_in = total_ff;
      rsp_in   = '0;
      if (!s_have_ff) begin
         rsp_in.status = ST_UNKNOWN;
      end else if (s_cmd_ff == CMD_ENROLL) begin
         wr_ent            = '0;
         wr_en             = 1'b1;
         ev_in[s_idx_ff]   = 1'b1;
         rsp_in.status     = ST_ENROLLED;
      end else if (!s_valid_ff) begin
         rsp_in.status = ST_UNKNOWN;
      end else begin
         priority if (s_cmd_ff == CMD_MARK) begin
            wr_ent.pend   = 1'b1;
            wr_en         = 1'b1;
            rsp_in.status = ST_MARKED;
         end else if (s_cmd_ff == CMD_DELETE) begin
            wr_ent          = '0;
            wr_en           = 1'b1;
            ev_in[s_idx_ff] = 1'b0;
            rsp_in.status   = ST_DELETED;
         end else if (s_replay_ff) begin
            rsp_in.status = ST_REPLAY;
         end else if (s_ent_ff.pend) begin
            wr_ent.last              = s_fc_ff;
            wr_ent.seen              = 1'b1;
            wr_ent.down              = s_ent_ff.down + 32'd1;
            wr_ent.tries             = s_ent_ff.tries + 16'd1;
            wr_en                    = 1'b1;
            rsp_in.send_downlink     = 1'b1;
            rsp_in.downlink_is_reset = 1'b1;
            rsp_in.status            = ST_RESEND;
         end else if (!s_ok_ff) begin
            rsp_in.status = ST_BADPAY;
         end else begin
            rsp_in.status = ST_VALID;
            // A gap at or over the threshold means the sensor restarted.
            if (s_ent_ff.seen) begin
               if (s_gap_ff >= gap_threshold) begin
                  rsp_in.status = ST_RESTART;
               end else begin
                  rsp_in.lost_added = s_gap_ff;
                  wr_ent.lost       = s_ent_ff.lost + s_gap_ff;
                  total_in          = total_ff + s_gap_ff;
               end
            end
            wr_ent.last = s_fc_ff;
            wr_ent.seen = 1'b1;
            wr_en       = 1'b1;
            if (ack_enable) begin
               wr_ent.down          = s_ent_ff.down + 32'd1;
               rsp_in.send_downlink = 1'b1;
            end
         end
      end
      // Entry fields of the result show the entry after the update.
      if (rsp_in.status != ST_UNKNOWN) begin
         rsp_in.downlink_count      = wr_ent.down;
         rsp_in.reset_attempt_count = wr_ent.tries;
         rsp_in.device_lost         = wr_ent.lost;
      end
      rsp_in.all_lost = total_in;
   end

   // Table and tally registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff    <= '0;
         total_ff <= 32'd0;
      end else if (ctl.exec) begin
         ev_ff    <= ev_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec && wr_en) begin
         tbl_ff[s_idx_ff] <= wr_ent;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

/* rtl/ufct_checker.sv */
// Port-level checker for the tracker, bound to the top level.
// Depends on ufct_pkg and the tracker assertion macros.
`default_nettype none
`include "uplink_frame_counter_tracker_core_macros.svh"

module ufct_checker
   import ufct_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire rsp_type     rsp_item,
   input wire logic        pready
);

   logic accept;
   logic unknown_rsp;
   logic entry_clear;

   assign accept      = start && !busy;
   assign unknown_rsp = rsp_valid && (rsp_item.status == ST_UNKNOWN);
   assign entry_clear = (rsp_item.downlink_count == 32'd0) &&
                        (rsp_item.device_lost == 32'd0) &&
                        !rsp_item.send_downlink && pready;

   // An accepted item blocks the next one for exactly one cycle.
   `UFCT_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "busy did not follow accept")
   `UFCT_ASSERT_NEXT(a_busy_short, clock, reset, busy, !busy, "busy held longer than one cycle")

   // Every accepted item gives its result once its read and update steps are done.
   `UFCT_ASSERT_NOW(a_result_time, clock, reset, accept |-> ##3 rsp_valid, "result missing")

   // Result strobes are never back to back.
   `UFCT_ASSERT_NEXT(a_rsp_gap, clock, reset, rsp_valid, !rsp_valid, "results back to back")

   // An unknown sensor reports no entry values.
   `UFCT_ASSERT_NOW(a_unknown_zero, clock, reset, unknown_rsp |-> entry_clear, "unknown has data")

endmodule

bind uplink_frame_counter_tracker_core ufct_checker u_ufct_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item),
   .pready    (pready)
);

`default_nettype wire
